>>> rtl/core/mopc_pkg.sv
// Package for the memory-operation profile counters: sizes, codes, types, classifiers.
`timescale 1ns / 1ps
package mopc_pkg;

  localparam int CALLER_SLOTS    = 8;
  localparam int TARGET_COUNT    = 2;
  localparam int OPERATION_COUNT = 3;

  localparam int SUMMARY_WORDS = 39;
  localparam int SLOT_WORDS    = 6;
  localparam int PROFILE_WORDS = SUMMARY_WORDS + SLOT_WORDS * CALLER_SLOTS;
  localparam int BUFFER_WORDS  = TARGET_COUNT * OPERATION_COUNT * PROFILE_WORDS;
  localparam int STORE_WORDS   = 2 * BUFFER_WORDS;

  localparam int ADDR_W = $clog2(STORE_WORDS);
  localparam int SLOT_W = (CALLER_SLOTS > 1) ? $clog2(CALLER_SLOTS) : 1;
  localparam int IDX_W  = (SLOT_W > 4) ? SLOT_W : 4;

  // item commands
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_SWAP   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // result status
  localparam logic [1:0] ST_SLOT     = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  localparam logic [1:0] OP_COPY    = 2'd0;
  localparam logic [1:0] OP_MOVE    = 2'd1;
  localparam logic [1:0] OP_SET     = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  // counter fields visited by the sequencer; summary fields first, in step order
  localparam logic [4:0] F_CALLS   = 5'd0;
  localparam logic [4:0] F_BYTES   = 5'd1;
  localparam logic [4:0] F_SAMPLES = 5'd2;
  localparam logic [4:0] F_CYCLES  = 5'd3;
  localparam logic [4:0] F_MAXCYC  = 5'd4;
  localparam logic [4:0] F_MINLEN  = 5'd5;
  localparam logic [4:0] F_MAXLEN  = 5'd6;
  localparam logic [4:0] F_ALC     = 5'd7;
  localparam logic [4:0] F_ALB     = 5'd8;
  localparam logic [4:0] F_DST     = 5'd9;
  localparam logic [4:0] F_SRC     = 5'd10;
  localparam logic [4:0] F_BINC    = 5'd11;
  localparam logic [4:0] F_BINB    = 5'd12;
  localparam logic [4:0] F_OVFC    = 5'd13;
  localparam logic [4:0] F_OVFB    = 5'd14;
  localparam logic [4:0] F_SCALLER = 5'd15;
  localparam logic [4:0] F_SCALLS  = 5'd16;
  localparam logic [4:0] F_SBYTES  = 5'd17;
  localparam logic [4:0] F_SCYC    = 5'd18;
  localparam logic [4:0] F_SMIN    = 5'd19;
  localparam logic [4:0] F_SMAX    = 5'd20;
  localparam logic [4:0] F_PROBE   = 5'd21;
  localparam logic [4:0] F_READ    = 5'd22;

  localparam int W_ALIGN_CALLS = 7;
  localparam int W_ALIGN_BYTES = 11;
  localparam int W_SRC_REGION  = 15;
  localparam int W_DST_REGION  = 20;
  localparam int W_BIN_CALLS   = 25;
  localparam int W_BIN_BYTES   = 31;
  localparam int W_OVF_CALLS   = 37;

  typedef struct packed {
    logic              load;
    logic              wr;
    logic              clr;
    logic              clr_all;
    logic              finish;
    logic [4:0]        field;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] clr_cnt;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic sel_valid;
    logic out_free;
  } stat_t;

  function automatic logic [2:0] region_of(input logic [31:0] a);
    if (a >= 32'h0001_0000 && a < 32'h0003_0000) return 3'd0;
    if (a >= 32'h2000_0000 && a < 32'h2020_0A00) return 3'd1;
    if (a >= 32'h7000_0000 && a < 32'h7200_0000) return 3'd2;
    if (a >= 32'h9800_0000 && a < 32'hA000_0000) return 3'd3;
    return 3'd4;
  endfunction

  function automatic logic [1:0] align_of(input logic [31:0] d, input logic [31:0] s,
                                          input logic [1:0] op);
    if (op == OP_SET) begin
      if (d[3:0] == 4'd0) return 2'd0;
      if (d[1:0] == 2'd0) return 2'd1;
      return 2'd2;
    end
    if ((d[3:0] | s[3:0]) == 4'd0) return 2'd0;
    if ((d[1:0] | s[1:0]) == 2'd0) return 2'd1;
    if ((d[1:0] ^ s[1:0]) == 2'd0) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [2:0] bin_of(input logic [31:0] n);
    if (n <= 32'd64) return 3'd0;
    if (n <= 32'd256) return 3'd1;
    if (n <= 32'd1024) return 3'd2;
    if (n <= 32'd4096) return 3'd3;
    if (n <= 32'd16384) return 3'd4;
    return 3'd5;
  endfunction

endpackage

>>> rtl/core/mopc_ctrl.sv
// Sequencer for the profile counters: item intake, word walk, clear sweep, result hand-off.
`timescale 1ns / 1ps
module mopc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [1:0]       cmd,
  input  mopc_pkg::stat_t  stat,
  output mopc_pkg::cmd_t   ctl
);
  import mopc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [1:0] P_SUM   = 2'd0;
  localparam logic [1:0] P_PROBE = 2'd1;
  localparam logic [1:0] P_TAIL  = 2'd2;
  localparam logic [1:0] P_READ  = 2'd3;

  localparam logic [ADDR_W-1:0] LAST_ALL = ADDR_W'(STORE_WORDS - 1);
  localparam logic [ADDR_W-1:0] LAST_BUF = ADDR_W'(BUFFER_WORDS - 1);

  logic [2:0]        state, state_next;
  logic [1:0]        phase, phase_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              all, all_next;
  logic              accept;
  logic              tail_last;
  logic [ADDR_W-1:0] clr_last;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign tail_last  = stat.sel_valid ? (idx == IDX_W'(SLOT_WORDS - 1)) : (idx == IDX_W'(1));
  assign clr_last   = all ? LAST_ALL : LAST_BUF;

  always_comb begin
    state_next = state;
    phase_next = phase;
    idx_next   = idx;
    cnt_next   = cnt;
    all_next   = all;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_RECORD: state_next = S_CHK;
            CMD_SWAP:   state_next = S_DONE;
            CMD_READ: begin
              phase_next = P_READ;
              state_next = S_RD;
            end
            CMD_CLEAR: begin
              all_next   = 1'b0;
              cnt_next   = '0;
              state_next = S_CLR;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        phase_next = P_SUM;
        idx_next   = '0;
        state_next = stat.ignore ? S_DONE : S_RD;
      end
      S_RD: state_next = S_WR;
      S_WR: begin
        state_next = S_RD;
        idx_next   = idx + IDX_W'(1);
        unique case (phase)
          P_SUM: if (idx == IDX_W'(F_BINB)) begin
            phase_next = P_PROBE;
            idx_next   = '0;
          end
          P_PROBE: if (idx == IDX_W'(CALLER_SLOTS - 1)) begin
            phase_next = P_TAIL;
            idx_next   = '0;
          end
          P_TAIL: if (tail_last) state_next = S_DONE;
          P_READ: state_next = S_DONE;
          default: state_next = S_DONE;
        endcase
      end
      S_CLR: begin
        cnt_next = cnt + ADDR_W'(1);
        if (cnt == clr_last) state_next = all ? S_IDLE : S_DONE;
      end
      S_DONE: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      phase <= P_SUM;
      idx   <= '0;
      cnt   <= '0;
      all   <= 1'b1;
    end else begin
      state <= state_next;
      phase <= phase_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
      all   <= all_next;
    end
  end

  always_comb begin
    ctl         = '0;
    ctl.load    = accept;
    ctl.wr      = (state == S_WR);
    ctl.clr     = (state == S_CLR);
    ctl.clr_all = all;
    ctl.finish  = (state == S_DONE) && stat.out_free;
    ctl.slot    = idx[SLOT_W-1:0];
    ctl.clr_cnt = cnt;
    case (phase)
      P_SUM:   ctl.field = 5'(idx);
      P_PROBE: ctl.field = F_PROBE;
      P_TAIL:  ctl.field = stat.sel_valid ? (F_SCALLER + 5'(idx)) : (F_OVFC + 5'(idx));
      default: ctl.field = F_READ;
    endcase
  end

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> $past(state) == S_RD)
    else $error("write step without read step");

  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && stat.out_free) |=> state == S_IDLE)
    else $error("result not handed off");

  a_clr_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> cnt <= clr_last)
    else $error("clear sweep ran past its end");

endmodule

>>> rtl/core/mopc_dp.sv
// Datapath for the profile counters: item registers, counter store, update logic, result register.
`timescale 1ns / 1ps
module mopc_dp (
  input  logic             clk,
  input  logic             rst,
  input  mopc_pkg::cmd_t   ctl,
  output mopc_pkg::stat_t  stat,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [31:0]      wr_data,
  input  logic [1:0]       cmd,
  input  logic [31:0]      task_handle,
  input  logic [31:0]      caller_addr,
  input  logic [31:0]      dst_addr,
  input  logic [31:0]      src_addr,
  input  logic [31:0]      length,
  input  logic [1:0]       operation,
  input  logic [31:0]      cycles,
  input  logic             cyc_valid,
  input  logic             read_target,
  input  logic [1:0]       read_operation,
  input  logic [6:0]       read_index,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [31:0]      read_data,
  output logic [1:0]       status
);
  import mopc_pkg::*;

  logic [31:0] mem [STORE_WORDS];
  logic [31:0] rdata;

  logic [31:0] target_a, target_b;
  logic        active;

  logic [1:0]        cmd_q;
  logic [31:0]       caller, n, cyc;
  logic              cv, is_set, ign, rd_ok;
  logic [1:0]        aln;
  logic [2:0]        rdst, rsrc, bin;
  logic [ADDR_W-1:0] base;
  logic [6:0]        ridx;
  logic [31:0]       rd_q;

  logic              found, sel_valid;
  logic [SLOT_W-1:0] sel;

  logic              tgt_in, ign_in, buf_in;
  logic [3:0]        prof_in;
  logic [ADDR_W-1:0] off, addr, slot_base, clr_addr;
  logic [4:0]        sub;
  logic [31:0]       addend, wdata, sum;
  logic              we, rec_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_a <= '0;
      target_b <= '0;
    end else if (wr_en) begin
      if (wr_index) target_b <= wr_data;
      else target_a <= wr_data;
    end
  end

  assign tgt_in  = (task_handle != target_a);
  assign ign_in  = (task_handle == 32'd0) || (length == 32'd0) || (operation == OP_INVALID)
                || ((task_handle != target_a) && (task_handle != target_b));
  assign buf_in  = (cmd == CMD_READ) ? ~active : active;
  assign prof_in = (cmd == CMD_READ)
                 ? 4'({buf_in, read_target}) * 4'(OPERATION_COUNT) + 4'(read_operation)
                 : 4'({buf_in, tgt_in}) * 4'(OPERATION_COUNT) + 4'(operation);

  always_ff @(posedge clk) begin
    if (rst) active <= 1'b0;
    else if (ctl.load && cmd == CMD_SWAP) active <= ~active;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= cmd;
      caller <= {caller_addr[31:1], 1'b0};
      n      <= length;
      cyc    <= cycles;
      cv     <= cyc_valid;
      is_set <= (operation == OP_SET);
      ign    <= ign_in;
      aln    <= align_of(dst_addr, src_addr, operation);
      rdst   <= region_of(dst_addr);
      rsrc   <= region_of(src_addr);
      bin    <= bin_of(length);
      base   <= ADDR_W'(prof_in) * ADDR_W'(PROFILE_WORDS);
      ridx   <= read_index;
      rd_ok  <= (read_operation != OP_INVALID) && (32'(read_index) < 32'(PROFILE_WORDS));
    end
  end

  assign sub       = ctl.field - F_SCALLER;
  assign slot_base = ADDR_W'(SUMMARY_WORDS) + ADDR_W'(sel) * ADDR_W'(SLOT_WORDS);

  always_comb begin
    case (ctl.field) inside
      F_ALC:   off = ADDR_W'(W_ALIGN_CALLS) + ADDR_W'(aln);
      F_ALB:   off = ADDR_W'(W_ALIGN_BYTES) + ADDR_W'(aln);
      F_DST:   off = ADDR_W'(W_DST_REGION) + ADDR_W'(rdst);
      F_SRC:   off = ADDR_W'(W_SRC_REGION) + ADDR_W'(rsrc);
      F_BINC:  off = ADDR_W'(W_BIN_CALLS) + ADDR_W'(bin);
      F_BINB:  off = ADDR_W'(W_BIN_BYTES) + ADDR_W'(bin);
      F_OVFC, F_OVFB: off = ADDR_W'(W_OVF_CALLS) + ADDR_W'(ctl.field - F_OVFC);
      F_SCALLER, F_SCALLS, F_SBYTES, F_SCYC, F_SMIN, F_SMAX: off = slot_base + ADDR_W'(sub);
      F_PROBE: off = ADDR_W'(SUMMARY_WORDS) + ADDR_W'(ctl.slot) * ADDR_W'(SLOT_WORDS);
      F_READ:  off = rd_ok ? ADDR_W'(ridx) : '0;
      default: off = ADDR_W'(ctl.field);
    endcase
  end

  assign clr_addr = ctl.clr_all ? ctl.clr_cnt
                  : (active ? ctl.clr_cnt : ADDR_W'(BUFFER_WORDS) + ctl.clr_cnt);
  assign addr     = ctl.clr ? clr_addr : base + off;

  always_comb begin
    case (ctl.field) inside
      F_CALLS, F_ALC, F_BINC, F_OVFC, F_SCALLS: addend = 32'd1;
      F_SAMPLES: addend = {31'd0, cv};
      F_BYTES, F_ALB, F_DST, F_BINB, F_OVFB, F_SBYTES: addend = n;
      F_SRC: addend = is_set ? 32'd0 : n;
      F_CYCLES, F_SCYC: addend = cv ? cyc : 32'd0;
      default: addend = 32'd0;
    endcase
    sum = rdata + addend;
    case (ctl.field) inside
      F_MAXCYC: wdata = (cv && cyc > rdata) ? cyc : rdata;
      F_MINLEN, F_SMIN: wdata = (rdata == 32'd0 || n < rdata) ? n : rdata;
      F_MAXLEN, F_SMAX: wdata = (n > rdata) ? n : rdata;
      F_SCALLER: wdata = (rdata == 32'd0) ? caller : rdata;
      default: wdata = sum;
    endcase
  end

  assign rec_we = ctl.wr && (ctl.field != F_PROBE) && (ctl.field != F_READ);
  assign we     = ctl.clr || rec_we;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= ctl.clr ? 32'd0 : wdata;
    rdata <= mem[addr];
  end

  // caller search: a match wins over an earlier empty slot
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      found     <= 1'b0;
      sel_valid <= 1'b0;
      sel       <= '0;
    end else if (ctl.wr && ctl.field == F_PROBE && !found) begin
      if (rdata == caller) begin
        found     <= 1'b1;
        sel_valid <= 1'b1;
        sel       <= ctl.slot;
      end else if (!sel_valid && rdata == 32'd0) begin
        sel_valid <= 1'b1;
        sel       <= ctl.slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) rd_q <= 32'd0;
    else if (ctl.wr && ctl.field == F_READ) rd_q <= rd_ok ? rdata : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (ctl.finish) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      read_data <= rd_q;
      if (cmd_q != CMD_RECORD) status <= ST_DONE;
      else if (ign) status <= ST_IGNORED;
      else status <= sel_valid ? ST_SLOT : ST_OVERFLOW;
    end
  end

  assign stat.ignore    = ign;
  assign stat.sel_valid = sel_valid;
  assign stat.out_free  = !result_valid || !result_stall;

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> result_valid)
    else $error("finished item not presented");

  a_no_double: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !ctl.finish)
    else $error("result overwritten while stalled");

  a_found_sel: assert property (@(posedge clk) disable iff (rst)
    found |-> sel_valid)
    else $error("caller match without selected slot");

endmodule

>>> rtl/core/memory_op_profile_counters.sv
// Top level of the memory-operation profile counters.
//  channel  | handshake                  | payload
//  item     | item_valid / item_stall    | cmd .. read_index
//  result   | result_valid / result_stall| read_data, status
//  config   | wr_en                      | wr_index, wr_data
// Record: read-modify-write per counter word (single-port store) over the summary words, a probe
//   of each caller slot, then the caller slot's words or, on caller overflow, the overflow words;
//   an ignored record skips the walk, a read takes one word, a clear sweeps the buffer's words.
// After reset the store is swept to zero, one word a cycle: all 1044 words, item_stall high.
// The result sits in an output register; a stalled result holds the next item's hand-off.
`timescale 1ns / 1ps
module memory_op_profile_counters (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] task_handle,
  input  logic [31:0] caller_addr,
  input  logic [31:0] dst_addr,
  input  logic [31:0] src_addr,
  input  logic [31:0] length,
  input  logic [1:0]  operation,
  input  logic [31:0] cycles,
  input  logic        cyc_valid,
  input  logic        read_target,
  input  logic [1:0]  read_operation,
  input  logic [6:0]  read_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] read_data,
  output logic [1:0]  status
);
  import mopc_pkg::*;

  cmd_t  ctl;
  stat_t stat;

  mopc_ctrl u_ctrl (
    .clk, .rst, .item_valid, .item_stall, .cmd, .stat, .ctl
  );

  mopc_dp u_dp (
    .clk, .rst, .ctl, .stat, .wr_en, .wr_index, .wr_data, .cmd, .task_handle,
    .caller_addr, .dst_addr, .src_addr, .length, .operation, .cycles, .cyc_valid,
    .read_target, .read_operation, .read_index, .result_valid, .result_stall,
    .read_data, .status
  );

endmodule

>>> tb/tb.sv
// Testbench for the memory-operation profile counters: random and directed items checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import mopc_pkg::*;

  localparam int PW = PROFILE_WORDS;
  localparam int BW = BUFFER_WORDS;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] task_handle, caller_addr, dst_addr, src_addr, length, cycles;
    logic [1:0]  operation;
    logic        cyc_valid, read_target;
    logic [1:0]  read_operation;
    logic [6:0]  read_index;
  } item_t;

  typedef struct {
    logic [31:0] read_data;
    logic [1:0]  status;
  } res_t;

  class profile_scoreboard;
    logic [31:0] handle_a, handle_b;
    logic        active;
    logic [31:0] store [STORE_WORDS];
    res_t        pending [$];
    int          errors;

    function void clear_all();
      handle_a = 0; handle_b = 0; active = 0; errors = 0;
      foreach (store[i]) store[i] = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      if (idx == 1'b0) handle_a = v; else handle_b = v;
    endfunction

    function logic [31:0] region(logic [31:0] a);
      if (a >= 32'h0001_0000 && a < 32'h0003_0000) return 0;
      if (a >= 32'h2000_0000 && a < 32'h2020_0A00) return 1;
      if (a >= 32'h7000_0000 && a < 32'h7200_0000) return 2;
      if (a >= 32'h9800_0000 && a < 32'hA000_0000) return 3;
      return 4;
    endfunction

    function int align(logic [31:0] d, logic [31:0] s, logic [1:0] op);
      if (op == OP_SET) return (d[3:0] == 0) ? 0 : (d[1:0] == 0) ? 1 : 2;
      if ((d[3:0] | s[3:0]) == 0) return 0;
      if ((d[1:0] | s[1:0]) == 0) return 1;
      if ((d[1:0] ^ s[1:0]) == 0) return 2;
      return 3;
    endfunction

    function int size_bin(logic [31:0] n);
      if (n <= 64) return 0;
      if (n <= 256) return 1;
      if (n <= 1024) return 2;
      if (n <= 4096) return 3;
      if (n <= 16384) return 4;
      return 5;
    endfunction

    function void minmax(int at, logic [31:0] n);
      if (store[at] == 0 || n < store[at]) store[at] = n;
      if (n > store[at+1]) store[at+1] = n;
    endfunction

    function logic [1:0] record(item_t it);
      int tgt, b, s, hit;
      logic [31:0] caller;
      caller = {it.caller_addr[31:1], 1'b0};
      if (it.task_handle == 0 || it.length == 0 || it.operation == OP_INVALID)
        return ST_IGNORED;
      if (it.task_handle == handle_a) tgt = 0;
      else if (it.task_handle == handle_b) tgt = 1;
      else return ST_IGNORED;
      b = ((int'(active) * TARGET_COUNT + tgt) * OPERATION_COUNT + it.operation) * PW;
      store[b] += 1;
      store[b+1] += it.length;
      if (it.cyc_valid) begin
        store[b+2] += 1;
        store[b+3] += it.cycles;
        if (it.cycles > store[b+4]) store[b+4] = it.cycles;
      end
      minmax(b + 5, it.length);
      s = align(it.dst_addr, it.src_addr, it.operation);
      store[b+W_ALIGN_CALLS+s] += 1;
      store[b+W_ALIGN_BYTES+s] += it.length;
      store[b+W_DST_REGION+region(it.dst_addr)] += it.length;
      if (it.operation != OP_SET) store[b+W_SRC_REGION+region(it.src_addr)] += it.length;
      s = size_bin(it.length);
      store[b+W_BIN_CALLS+s] += 1;
      store[b+W_BIN_BYTES+s] += it.length;
      hit = -1;
      for (int k = 0; k < CALLER_SLOTS; k++) begin
        s = b + SUMMARY_WORDS + SLOT_WORDS * k;
        if (store[s] == caller) begin hit = s; break; end
        if (hit < 0 && store[s] == 0) hit = s;
      end
      if (hit < 0) begin
        store[b+W_OVF_CALLS] += 1;
        store[b+W_OVF_CALLS+1] += it.length;
        return ST_OVERFLOW;
      end
      if (store[hit] == 0) store[hit] = caller;
      store[hit+1] += 1;
      store[hit+2] += it.length;
      if (it.cyc_valid) store[hit+3] += it.cycles;
      minmax(hit + 4, it.length);
      return ST_SLOT;
    endfunction

    function void note_item(item_t it);
      res_t r;
      logic inact;
      inact = ~active;
      r.read_data = 0;
      r.status = ST_DONE;
      case (it.cmd)
        CMD_RECORD: r.status = record(it);
        CMD_SWAP: active = inact;
        CMD_READ:
          if (it.read_operation < OPERATION_COUNT && it.read_index < PW)
            r.read_data = store[((int'(inact) * TARGET_COUNT + it.read_target)
                                 * OPERATION_COUNT + it.read_operation) * PW + it.read_index];
        default: for (int i = 0; i < BW; i++) store[int'(inact) * BW + i] = 0;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] d, logic [1:0] st);
      res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result data=%h status=%0d", d, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d !== e.read_data) begin
        $error("read_data expected %h actual %h", e.read_data, d);
        errors++;
      end
      if (st !== e.status) begin
        $error("status expected %0d actual %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, wr_en, wr_index;
  logic [31:0] wr_data;
  logic item_valid, item_stall, result_valid, result_stall;
  logic [1:0] cmd, operation, read_operation, status;
  logic [31:0] task_handle, caller_addr, dst_addr, src_addr, length, cycles, read_data;
  logic cyc_valid, read_target;
  logic [6:0] read_index;

  profile_scoreboard sb;
  logic [31:0] hnd_a, hnd_b;
  logic [31:0] callers [12];
  bit stall_free;

  memory_op_profile_counters dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_len();
    if (stall_free) return 0;
    case ($urandom_range(0, 19))
      0: return $urandom_range(10, 60);
      1, 2, 3: return $urandom_range(1, 4);
      default: return 0;
    endcase
  endfunction

  // result side stall
  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else if (stall_free) result_stall <= 1'b0;
    else result_stall <= ($urandom_range(0, 9) < 3);
  end

  always @(posedge clk)
    if (!rst && result_valid && !result_stall) sb.check_result(read_data, status);

  task automatic send_item(item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= it.cmd; task_handle <= it.task_handle; caller_addr <= it.caller_addr;
    dst_addr <= it.dst_addr; src_addr <= it.src_addr; length <= it.length;
    operation <= it.operation; cycles <= it.cycles; cyc_valid <= it.cyc_valid;
    read_target <= it.read_target; read_operation <= it.read_operation;
    read_index <= it.read_index;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= v;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    item_valid <= 1'b0;
    while (sb.pending.size() != 0 && n < 200000) begin @(posedge clk); n++; end
    repeat (100) @(posedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    int r;
    it.cmd = CMD_RECORD;
    it.task_handle = $urandom_range(0, 1) ? hnd_a : hnd_b;
    r = $urandom_range(0, 19);
    if (r == 0) it.task_handle = 0;
    else if (r == 1) it.task_handle = $urandom;
    it.caller_addr = ($urandom_range(0, 7) == 0) ? $urandom : callers[$urandom_range(0, 11)];
    case ($urandom_range(0, 5))
      0: it.dst_addr = 32'h0001_0000 + $urandom_range(0, 32'h1_FFFF);
      1: it.dst_addr = 32'h2000_0000 + $urandom_range(0, 32'h20_0A20);
      2: it.dst_addr = 32'h7000_0000 + $urandom_range(0, 32'h200_0010);
      3: it.dst_addr = 32'h9800_0000 + $urandom_range(0, 32'h800_0010);
      default: it.dst_addr = $urandom;
    endcase
    it.src_addr = $urandom_range(0, 1) ? ($urandom ^ it.dst_addr) : $urandom;
    if ($urandom_range(0, 2) == 0) it.src_addr[3:0] = $urandom_range(0, 1) ? 4'h0 : 4'h4;
    if ($urandom_range(0, 2) == 0) it.dst_addr[3:0] = $urandom_range(0, 1) ? 4'h0 : 4'h8;
    case ($urandom_range(0, 6))
      0: it.length = $urandom_range(0, 64);
      1: it.length = $urandom_range(60, 300);
      2: it.length = $urandom_range(250, 4200);
      3: it.length = $urandom_range(4000, 17000);
      4: it.length = $urandom;
      default: it.length = $urandom_range(1, 2000);
    endcase
    it.operation = ($urandom_range(0, 15) == 0) ? OP_INVALID : 2'($urandom_range(0, 2));
    it.cycles = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 500);
    it.cyc_valid = $urandom_range(0, 3) != 0;
    it.read_target = 1'($urandom);
    it.read_operation = 2'($urandom);
    it.read_index = 7'($urandom);
    r = $urandom_range(0, 99);
    if (r < 4) it.cmd = CMD_SWAP;
    else if (r < 5) it.cmd = CMD_CLEAR;
    else if (r < 25) begin
      it.cmd = CMD_READ;
      it.read_operation = ($urandom_range(0, 9) == 0) ? OP_INVALID : 2'($urandom_range(0, 2));
      it.read_index = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 86));
    end
    return it;
  endfunction

  initial begin
    item_t it;
    sb = new();
    sb.clear_all();
    stall_free = 0;
    rst = 1; wr_en = 0; wr_index = 0; wr_data = 0; item_valid = 0;
    cmd = 0; task_handle = 0; caller_addr = 0; dst_addr = 0; src_addr = 0; length = 0;
    operation = 0; cycles = 0; cyc_valid = 0; read_target = 0; read_operation = 0;
    read_index = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (callers[i]) callers[i] = $urandom;
    callers[0] = 0;
    callers[1] = 1;

    // directed: both targets equal, extremes, every command
    hnd_a = 32'hFFFF_FFFF; hnd_b = 32'hFFFF_FFFF;
    write_reg(1'b0, hnd_a); write_reg(1'b1, hnd_b);
    it = rand_item();
    it.cmd = CMD_RECORD; it.task_handle = hnd_a; it.operation = OP_COPY; it.cyc_valid = 1'b1;
    it.caller_addr = 32'hFFFF_FFFF; it.dst_addr = 0; it.src_addr = 32'hFFFF_FFFF;
    it.length = 32'hFFFF_FFFF; it.cycles = 32'hFFFF_FFFF;
    send_item(it);
    it.length = 1; it.cycles = 0; it.caller_addr = 0; send_item(it);
    it.caller_addr = 1; it.operation = OP_SET; send_item(it);
    it.operation = OP_INVALID; send_item(it);
    it.operation = OP_MOVE; it.length = 0; send_item(it);
    it.length = 5; it.task_handle = 0; send_item(it);
    for (int k = 0; k < 10; k++) begin
      it.task_handle = hnd_a; it.caller_addr = 32'h100 + 2 * k; it.length = 64 + k;
      send_item(it);
    end
    it.cmd = CMD_SWAP; send_item(it);
    it.cmd = CMD_READ; it.read_target = 1'b0;
    for (int k = 0; k < 4; k++) begin
      it.read_operation = 2'(k); it.read_index = 7'((k == 3) ? 0 : 5 + k * 40);
      send_item(it);
    end
    it.read_index = 7'd127; it.read_operation = OP_COPY; send_item(it);
    it.cmd = CMD_CLEAR; send_item(it);
    it.cmd = CMD_READ; it.read_index = 7'd0; send_item(it);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      hnd_a = (ph == 3) ? 32'h0 : $urandom;
      hnd_b = (ph == 2) ? hnd_a : (ph == 1) ? 32'hFFFF_FFFF : $urandom;
      write_reg(1'b0, hnd_a); write_reg(1'b1, hnd_b);
      if (ph == 3) hnd_a = 32'h1;
      stall_free = (ph == 1);
      for (int n = 0; n < 475; n++) send_item(rand_item());
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
